>>> rtl/rect_to_polar_converter_core_defines.svh
// Assertion macros for the rectangular to polar converter.
// Bodies expect a clock named clk and a synchronous reset named rst in scope.
`ifndef RECT_TO_POLAR_CONVERTER_CORE_DEFINES_SVH
`define RECT_TO_POLAR_CONVERTER_CORE_DEFINES_SVH

// Condition must hold in the same cycle as the trigger.
`define R2P_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Condition must hold in the cycle after the trigger.
`define R2P_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/r2p_pkg.sv
// Shared constants for the rectangular to polar converter.
// No dependencies.
`default_nettype none

package r2p_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int ANGLE_STEPS_DEF  = 16;

  // CORDIC datapath: samples prescaled so that they sit just below bit 40
  localparam int CORDIC_FRAC = 40;
  localparam int CORDIC_XW   = 44;
  localparam int CORDIC_ZW   = 35;   // angle in Q2.30 with headroom

  localparam int PHASE_W      = 16;
  localparam int PHASE_PI_Q13 = 25736;
  localparam int PHASE_SHIFT  = 17;  // Q2.30 -> Q3.13
  localparam int PHASE_ROUND  = 65536;

  localparam logic signed [CORDIC_ZW-1:0] PI_Q30 = CORDIC_ZW'(64'sd3373259426);
  // half pi placed so that the final rounding yields exactly 12868
  localparam logic signed [CORDIC_ZW-1:0] HALF_PI_Z = CORDIC_ZW'(64'sd1686634496);

  localparam logic [31:0] ATAN_Q30 [0:31] = '{
    32'h3243F6A9, 32'h1DAC6705, 32'h0FADBAFD, 32'h07F56EA7,
    32'h03FEAB77, 32'h01FFD55C, 32'h00FFFAAB, 32'h007FFF55,
    32'h003FFFEB, 32'h001FFFFD, 32'h00100000, 32'h00080000,
    32'h00040000, 32'h00020000, 32'h00010000, 32'h00008000,
    32'h00004000, 32'h00002000, 32'h00001000, 32'h00000800,
    32'h00000400, 32'h00000200, 32'h00000100, 32'h00000080,
    32'h00000040, 32'h00000020, 32'h00000010, 32'h00000008,
    32'h00000004, 32'h00000002, 32'h00000001, 32'h00000000
  };

endpackage

`default_nettype wire

>>> rtl/r2p_in_if.sv
// Sample channel: valid/ready handshake carrying one complex sample per item.
// No dependencies.
`default_nettype none

interface r2p_in_if #(
  parameter int SAMPLE_WIDTH = 16
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] real_part;
  logic signed [SAMPLE_WIDTH-1:0] imag_part;
  logic                           last_sample;

  modport source (output valid, real_part, imag_part, last_sample, input ready);
  modport sink (input valid, real_part, imag_part, last_sample, output ready);
endinterface

`default_nettype wire

>>> rtl/r2p_out_if.sv
// Result channel: valid/ready handshake carrying magnitude and phase per item.
// No dependencies.
`default_nettype none

interface r2p_out_if #(
  parameter int SAMPLE_WIDTH = 16
) ();
  logic                    valid;
  logic                    ready;
  logic [SAMPLE_WIDTH-1:0] magnitude;
  logic signed [15:0]      phase;
  logic                    last_result;

  modport source (output valid, magnitude, phase, last_result, input ready);
  modport sink (input valid, magnitude, phase, last_result, output ready);
endinterface

`default_nettype wire

>>> rtl/r2p_prep.sv
// Front stage: squares for the root, quadrant fold and prescale for CORDIC.
// Uses r2p_pkg and the r2p_in_if channel.
`default_nettype none

module r2p_prep import r2p_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  r2p_in_if.sink                        samples,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic signed [CORDIC_XW-1:0]   out_x,
  output logic signed [CORDIC_XW-1:0]   out_y,
  output logic signed [CORDIC_ZW-1:0]   out_z,
  output logic [2*SAMPLE_WIDTH-1:0]     out_rad,
  output logic                          out_last
);

  localparam int SW       = SAMPLE_WIDTH;
  localparam int PRESCALE = CORDIC_FRAC - SW;
  localparam int PAD      = CORDIC_XW - SW - 1 - PRESCALE;

  logic              en;
  logic signed [SW-1:0] re, im;
  logic              re_zero, im_zero, re_neg, im_neg;
  logic signed [SW:0] re_ext, im_ext, vx, vy;
  logic [SW-1:0]     ure, uim;
  logic [2*SW-1:0]   sq_re, sq_im;
  logic signed [CORDIC_XW-1:0] x_next, y_next;
  logic signed [CORDIC_ZW-1:0] z_next;
  logic [2*SW-1:0]   rad_next;

  assign en            = !out_valid || out_ready;
  assign samples.ready = en;

  always_comb begin
    re      = samples.real_part;
    im      = samples.imag_part;
    re_zero = (re == '0);
    im_zero = (im == '0);
    re_neg  = re[SW-1];
    im_neg  = im[SW-1];
    re_ext  = {re[SW-1], re};
    im_ext  = {im[SW-1], im};
    // left half plane: rotate by pi first
    vx      = re_neg ? -re_ext : re_ext;
    vy      = re_neg ? -im_ext : im_ext;
    x_next  = {{PAD{vx[SW]}}, vx, {PRESCALE{1'b0}}};
    y_next  = re_zero ? '0 : {{PAD{vy[SW]}}, vy, {PRESCALE{1'b0}}};
    if (re_zero) begin
      // y forced to 0 so no micro-rotation fires; angle is final here
      if (im_zero) begin
        z_next = '0;
      end else if (im_neg) begin
        z_next = -HALF_PI_Z;
      end else begin
        z_next = HALF_PI_Z;
      end
    end else if (re_neg) begin
      z_next = im_neg ? -PI_Q30 : PI_Q30;
    end else begin
      z_next = '0;
    end
    ure      = re_neg ? (~re + 1'b1) : re;
    uim      = im_neg ? (~im + 1'b1) : im;
    sq_re    = ure * ure;
    sq_im    = uim * uim;
    rad_next = sq_re + sq_im;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && samples.valid) begin
      out_x    <= x_next;
      out_y    <= y_next;
      out_z    <= z_next;
      out_rad  <= rad_next;
      out_last <= samples.last_sample;
    end
  end

endmodule

`default_nettype wire

>>> rtl/r2p_stage.sv
// One pipeline stage: a CORDIC vectoring micro-rotation and one root bit, each passed through once its steps run out.
// Uses r2p_pkg.
`default_nettype none

module r2p_stage import r2p_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int ANGLE_STEPS  = ANGLE_STEPS_DEF,
  parameter int STEP         = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [CORDIC_XW-1:0]   in_x,
  input  logic signed [CORDIC_XW-1:0]   in_y,
  input  logic signed [CORDIC_ZW-1:0]   in_z,
  input  logic [2*SAMPLE_WIDTH-1:0]     in_rad,
  input  logic [SAMPLE_WIDTH-1:0]       in_root,
  input  logic [SAMPLE_WIDTH:0]         in_rem,
  input  logic                          in_last,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic signed [CORDIC_XW-1:0]   out_x,
  output logic signed [CORDIC_XW-1:0]   out_y,
  output logic signed [CORDIC_ZW-1:0]   out_z,
  output logic [2*SAMPLE_WIDTH-1:0]     out_rad,
  output logic [SAMPLE_WIDTH-1:0]       out_root,
  output logic [SAMPLE_WIDTH:0]         out_rem,
  output logic                          out_last
);

  localparam int SW = SAMPLE_WIDTH;

  logic                        en;
  logic signed [CORDIC_XW-1:0] x_next, y_next;
  logic signed [CORDIC_ZW-1:0] z_next;
  logic [2*SW-1:0]             rad_next;
  logic [SW-1:0]               root_next;
  logic [SW:0]                 rem_next;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  generate
    if (STEP < ANGLE_STEPS) begin : g_rot
      logic signed [CORDIC_XW-1:0] xs, ys;
      logic signed [CORDIC_ZW-1:0] atan_z;
      always_comb begin
        xs     = in_x >>> STEP;
        ys     = in_y >>> STEP;
        atan_z = {{(CORDIC_ZW-32){1'b0}}, ATAN_Q30[STEP]};
        x_next = in_x;
        y_next = in_y;
        z_next = in_z;
        if (in_y[CORDIC_XW-1]) begin
          x_next = in_x - ys;
          y_next = in_y + xs;
          z_next = in_z - atan_z;
        end else if (in_y != '0) begin
          x_next = in_x + ys;
          y_next = in_y - xs;
          z_next = in_z + atan_z;
        end
      end
    end else begin : g_rot_pass
      always_comb begin
        x_next = in_x;
        y_next = in_y;
        z_next = in_z;
      end
    end

    if (STEP < SW) begin : g_root
      // restoring square root, two radicand bits per stage
      logic [SW+2:0] acc, trial, diff;
      logic          take;
      always_comb begin
        acc       = {in_rem, in_rad[2*SW-1 -: 2]};
        trial     = {1'b0, in_root, 2'b01};
        diff      = acc - trial;
        take      = (acc >= trial);
        rem_next  = take ? diff[SW:0] : acc[SW:0];
        root_next = {in_root[SW-2:0], take};
        rad_next  = {in_rad[2*SW-3:0], 2'b00};
      end
    end else begin : g_root_pass
      always_comb begin
        rem_next  = in_rem;
        root_next = in_root;
        rad_next  = in_rad;
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      out_x    <= x_next;
      out_y    <= y_next;
      out_z    <= z_next;
      out_rad  <= rad_next;
      out_root <= root_next;
      out_rem  <= rem_next;
      out_last <= in_last;
    end
  end

endmodule

`default_nettype wire

>>> rtl/r2p_final.sv
// Output stage: root rounding, phase rounding and clamp, result register.
// Uses r2p_pkg and the r2p_out_if channel.
`default_nettype none

module r2p_final import r2p_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [CORDIC_ZW-1:0]   in_z,
  input  logic [SAMPLE_WIDTH-1:0]       in_root,
  input  logic [SAMPLE_WIDTH:0]         in_rem,
  input  logic                          in_last,
  r2p_out_if.source                     results
);

  localparam int SW = SAMPLE_WIDTH;
  localparam logic signed [CORDIC_ZW-1:0] PMAX = CORDIC_ZW'(PHASE_PI_Q13);
  localparam logic signed [CORDIC_ZW-1:0] PMIN = -CORDIC_ZW'(PHASE_PI_Q13);

  logic                        en;
  logic [SW-1:0]               mag_next;
  logic signed [CORDIC_ZW-1:0] zsum, zr;
  logic signed [PHASE_W-1:0]   phase_next;

  assign en       = !results.valid || results.ready;
  assign in_ready = en;

  always_comb begin
    // round half up: bump when remainder exceeds root; top stays below 2^SW
    mag_next = in_root + SW'(in_rem > {1'b0, in_root});
    zsum     = in_z + CORDIC_ZW'(PHASE_ROUND);
    zr       = zsum >>> PHASE_SHIFT;
    if (zr > PMAX) begin
      phase_next = PHASE_W'(PMAX);
    end else if (zr < PMIN) begin
      phase_next = PHASE_W'(PMIN);
    end else begin
      phase_next = PHASE_W'(zr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (en) begin
      results.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      results.magnitude   <= mag_next;
      results.phase       <= phase_next;
      results.last_result <= in_last;
    end
  end

endmodule

`default_nettype wire

>>> rtl/rect_to_polar_converter_core.sv
// Rectangular to polar converter: magnitude by pipelined restoring root,
// phase by pipelined CORDIC vectoring, one item per clock when not stalled.
// Each stage holds one item and adds one root bit and one micro-rotation
// until its side runs out. Stalls move back stage by stage.
// Reset (rst, synchronous) clears the stage valid bits only.
`default_nettype none
`include "rect_to_polar_converter_core_defines.svh"

module rect_to_polar_converter_core import r2p_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int ANGLE_STEPS  = ANGLE_STEPS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  r2p_in_if.sink     samples,
  r2p_out_if.source  results
);

  localparam int SW     = SAMPLE_WIDTH;
  // root needs SW stages, angle needs ANGLE_STEPS; shorter side passes through
  localparam int STAGES = (SAMPLE_WIDTH > ANGLE_STEPS) ? SAMPLE_WIDTH : ANGLE_STEPS;

  // index k carries the item entering stage k; STAGES feeds the output stage
  logic                        vld  [0:STAGES];
  logic                        rdy  [0:STAGES];
  logic signed [CORDIC_XW-1:0] x_p  [0:STAGES];
  logic signed [CORDIC_XW-1:0] y_p  [0:STAGES];
  logic signed [CORDIC_ZW-1:0] z_p  [0:STAGES];
  logic [2*SW-1:0]             rad_p[0:STAGES];
  logic [SW-1:0]               root_p[0:STAGES];
  logic [SW:0]                 rem_p[0:STAGES];
  logic                        last_p[0:STAGES];

  // front: squares plus quadrant fold
  r2p_prep #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_prep (
    .clk      (clk),
    .rst      (rst),
    .samples  (samples),
    .out_ready(rdy[0]),
    .out_valid(vld[0]),
    .out_x    (x_p[0]),
    .out_y    (y_p[0]),
    .out_z    (z_p[0]),
    .out_rad  (rad_p[0]),
    .out_last (last_p[0])
  );

  // partial root and remainder start empty
  assign root_p[0] = '0;
  assign rem_p[0]  = '0;

  generate
    for (genvar k = 0; k < STAGES; k++) begin : g_stage
      r2p_stage #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH),
        .ANGLE_STEPS (ANGLE_STEPS),
        .STEP        (k)
      ) u_stage (
        .clk      (clk),
        .rst      (rst),
        .in_valid (vld[k]),
        .in_ready (rdy[k]),
        .in_x     (x_p[k]),
        .in_y     (y_p[k]),
        .in_z     (z_p[k]),
        .in_rad   (rad_p[k]),
        .in_root  (root_p[k]),
        .in_rem   (rem_p[k]),
        .in_last  (last_p[k]),
        .out_ready(rdy[k+1]),
        .out_valid(vld[k+1]),
        .out_x    (x_p[k+1]),
        .out_y    (y_p[k+1]),
        .out_z    (z_p[k+1]),
        .out_rad  (rad_p[k+1]),
        .out_root (root_p[k+1]),
        .out_rem  (rem_p[k+1]),
        .out_last (last_p[k+1])
      );
    end
  endgenerate

  // back: rounding, clamp, and the result register
  r2p_final #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_final (
    .clk     (clk),
    .rst     (rst),
    .in_valid(vld[STAGES]),
    .in_ready(rdy[STAGES]),
    .in_z    (z_p[STAGES]),
    .in_root (root_p[STAGES]),
    .in_rem  (rem_p[STAGES]),
    .in_last (last_p[STAGES]),
    .results (results)
  );

  // an empty or draining result register lets the whole pipe move
  `R2P_ASSERT_SAME(a_ready_when_drained, (!results.valid || results.ready), samples.ready, "input blocked while output drains")
  // an accepted item lands in the front stage
  `R2P_ASSERT_NEXT(a_accept_fills_front, (samples.valid && samples.ready), vld[0], "accepted item lost at front stage")
  // a blocked tail item stays put
  `R2P_ASSERT_NEXT(a_tail_held, (vld[STAGES] && !rdy[STAGES]), vld[STAGES], "stalled tail item dropped")
  // zero magnitude only comes from a zero sample, whose phase is zero
  `R2P_ASSERT_SAME(a_zero_phase, (results.valid && results.magnitude == '0), (results.phase == '0), "nonzero phase on zero sample")

endmodule

`default_nettype wire
